FILE: sv/tcee_pkg.sv
// ----------------------------------------------------------------------------
// tcee_pkg: shared types and constants of the text console escape engine
// Result opcodes, the configuration record, the command record that travels
// from the front end to the back end, and default sizes.
// ----------------------------------------------------------------------------
package tcee_pkg;

	localparam int MAX_ROWS_DEF    = 64;
	localparam int MAX_COLS_DEF    = 256;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int COL_W = 8;
	localparam int ROW_W = 6;

	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_SCROLL = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_WINDOW_OFFSET  = 3'd0,
		REG_WINDOW_HEIGHT  = 3'd1,
		REG_WINDOW_WIDTH   = 3'd2,
		REG_SCREEN_STRIDE  = 3'd3,
		REG_AUTO_LINE_FEED = 3'd4,
		REG_BELL_ENABLE    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] window_offset;
		logic [6:0]  window_height;
		logic [8:0]  window_width;
		logic [8:0]  screen_stride;
		logic        auto_line_feed;
		logic        bell_enable;
	} cfg_t;

	// One classified byte: the first result, an optional trailing scroll and
	// the cursor position after the byte.
	typedef struct packed {
		op_t              op;
		logic             scroll2;
		logic [7:0]       ch;
		logic [7:0]       attr;
		logic [COL_W-1:0] wr_col;
		logic [ROW_W-1:0] wr_row;
		logic             bell;
		logic [COL_W-1:0] cur_col;
		logic [ROW_W-1:0] cur_row;
	} cmd_t;

endpackage

FILE: sv/tcee_front.sv
// ----------------------------------------------------------------------------
// tcee_front: byte classifier and console state
// Holds the cursor, the attribute and the escape parser, and turns each
// accepted byte into one command record for the back end.
// ----------------------------------------------------------------------------
module tcee_front
	import tcee_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       take,
	input  logic [7:0] char_in,
	output cmd_t       cmd
);

	localparam logic [7:0] CH_BEL = 8'd7;
	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_FF  = 8'd12;
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_ESC = 8'd27;
	localparam logic [7:0] CH_SP  = 8'd32;
	localparam logic [7:0] CH_DEL = 8'd127;

	typedef enum logic [2:0] {
		ES_OPEN,
		ES_CSI,
		ES_ZERO,
		ES_BOLD,
		ES_ULINE,
		ES_THREE,
		ES_COLOR
	} esc_t;

	logic [COL_W-1:0] col_q, col_n;
	logic [ROW_W-1:0] row_q, row_n;
	logic [7:0]       attr_q, attr_n;
	logic             esc_act_q, esc_act_n;
	esc_t             esc_st_q, esc_st_n, esc_nx;
	logic [2:0]       color_q, color_n;
	logic [8:0]       eff_h, eff_w;
	logic             next_ok, done, consumed, scroll;
	logic [8:0]       row_inc, col_inc;

	// ANSI color number to text-mode color bits.
	function automatic logic [2:0] color_bits(input logic [2:0] n);
		logic [2:0] r;
		case (n)
			3'd0: r = 3'd0;
			3'd1: r = 3'd4;
			3'd2: r = 3'd2;
			3'd3: r = 3'd6;
			3'd4: r = 3'd1;
			3'd5: r = 3'd5;
			3'd6: r = 3'd3;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

	always_comb begin
		if (cfg.window_height == 7'd0)
			eff_h = 9'd1;
		else if ({2'b00, cfg.window_height} > 9'(MAX_ROWS))
			eff_h = 9'(MAX_ROWS);
		else
			eff_h = {2'b00, cfg.window_height};
		if (cfg.window_width == 9'd0)
			eff_w = 9'd1;
		else if (cfg.window_width > 9'(MAX_COLS))
			eff_w = 9'(MAX_COLS);
		else
			eff_w = cfg.window_width;
	end

	assign row_inc = {3'b000, row_q} + 9'd1;
	assign col_inc = {1'b0, col_q} + 9'd1;

	always_comb begin
		col_n     = col_q;
		row_n     = row_q;
		attr_n    = attr_q;
		esc_act_n = esc_act_q;
		esc_st_n  = esc_st_q;
		color_n   = color_q;
		esc_nx    = ES_OPEN;
		next_ok   = 1'b0;
		done      = 1'b0;
		consumed  = 1'b0;
		scroll    = 1'b0;
		cmd       = '0;
		cmd.op    = OP_NONE;
		cmd.wr_col = col_q;
		cmd.wr_row = row_q;

		if (esc_act_q) begin
			unique case (esc_st_q)
				ES_OPEN: begin
					if (char_in == "[") begin
						esc_nx  = ES_CSI;
						next_ok = 1'b1;
					end
				end
				ES_CSI: begin
					if (char_in == "0") begin
						esc_nx  = ES_ZERO;
						next_ok = 1'b1;
					end else if (char_in == "3") begin
						esc_nx  = ES_THREE;
						next_ok = 1'b1;
					end else if (char_in == "A") begin
						if (row_q != '0)
							row_n = row_q - 1'b1;
						done = 1'b1;
					end else if (char_in == "B") begin
						if (row_inc < eff_h)
							row_n = row_inc[ROW_W-1:0];
						done = 1'b1;
					end else if (char_in == "C") begin
						if (col_inc < eff_w)
							col_n = col_inc[COL_W-1:0];
						done = 1'b1;
					end else if (char_in == "D") begin
						if (col_q != '0)
							col_n = col_q - 1'b1;
						done = 1'b1;
					end
				end
				ES_ZERO: begin
					if (char_in == "m") begin
						attr_n = attr_q & 8'h77;
						done   = 1'b1;
					end else if (char_in == "1") begin
						esc_nx  = ES_BOLD;
						next_ok = 1'b1;
					end else if (char_in == "4") begin
						esc_nx  = ES_ULINE;
						next_ok = 1'b1;
					end
				end
				ES_BOLD: begin
					if (char_in == "m") begin
						attr_n = attr_q | 8'h08;
						done   = 1'b1;
					end
				end
				ES_ULINE: begin
					if (char_in == "m") begin
						attr_n = attr_q | 8'h80;
						done   = 1'b1;
					end
				end
				ES_THREE: begin
					if (char_in >= "0" && char_in <= "7") begin
						esc_nx  = ES_COLOR;
						color_n = char_in[2:0];
						next_ok = 1'b1;
					end
				end
				ES_COLOR: begin
					if (char_in == "m") begin
						attr_n = {attr_q[7:3], color_bits(color_q)};
						done   = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (next_ok) begin
				esc_st_n = esc_nx;
				consumed = 1'b1;
			end else begin
				esc_act_n = 1'b0;
				esc_st_n  = ES_OPEN;
				consumed  = done;
			end
		end

		// An unmatched escape byte falls through as an ordinary byte.
		if (!consumed) begin
			if (char_in == CH_BEL) begin
				cmd.bell = cfg.bell_enable;
			end else if (char_in == CH_BS || char_in == CH_DEL) begin
				if (col_q != '0) begin
					col_n = col_q - 1'b1;
				end else if (row_q != '0) begin
					row_n = row_q - 1'b1;
					col_n = COL_W'(eff_w - 9'd1);
				end
				if (char_in == CH_DEL) begin
					cmd.op     = OP_WRITE;
					cmd.wr_col = col_n;
					cmd.wr_row = row_n;
					cmd.ch     = CH_SP;
					cmd.attr   = attr_q;
				end
			end else if (char_in == CH_LF) begin
				col_n = '0;
				if (row_inc >= eff_h) begin
					row_n  = ROW_W'(eff_h - 9'd1);
					scroll = 1'b1;
				end else begin
					row_n = row_inc[ROW_W-1:0];
				end
			end else if (char_in == CH_FF) begin
				col_n    = '0;
				row_n    = '0;
				cmd.op   = OP_CLEAR;
				cmd.attr = attr_q;
			end else if (char_in == CH_CR) begin
				col_n = '0;
				if (cfg.auto_line_feed) begin
					if (row_inc >= eff_h) begin
						row_n  = ROW_W'(eff_h - 9'd1);
						scroll = 1'b1;
					end else begin
						row_n = row_inc[ROW_W-1:0];
					end
				end
			end else if (char_in == CH_ESC) begin
				esc_act_n = 1'b1;
				esc_st_n  = ES_OPEN;
			end else if (char_in < CH_SP) begin
				// Other control bytes only report the cursor.
			end else begin
				cmd.op   = OP_WRITE;
				cmd.ch   = char_in;
				cmd.attr = attr_q;
				if (col_inc >= eff_w) begin
					col_n = '0;
					if (row_inc >= eff_h) begin
						row_n  = ROW_W'(eff_h - 9'd1);
						scroll = 1'b1;
					end else begin
						row_n = row_inc[ROW_W-1:0];
					end
				end else begin
					col_n = col_inc[COL_W-1:0];
				end
			end
		end

		if (scroll) begin
			if (cmd.op == OP_NONE) begin
				cmd.op   = OP_SCROLL;
				cmd.attr = attr_q;
			end else begin
				cmd.scroll2 = 1'b1;
			end
		end
		cmd.cur_col = col_n;
		cmd.cur_row = row_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			attr_q    <= 8'h0f;
			esc_act_q <= 1'b0;
			esc_st_q  <= ES_OPEN;
			color_q   <= '0;
		end else if (take) begin
			col_q     <= col_n;
			row_q     <= row_n;
			attr_q    <= attr_n;
			esc_act_q <= esc_act_n;
			esc_st_q  <= esc_st_n;
			color_q   <= color_n;
		end
	end

endmodule

FILE: sv/tcee_queue.sv
// ----------------------------------------------------------------------------
// tcee_queue: command queue between front end and back end
// A small register queue with a full flag and a head that is always visible.
// ----------------------------------------------------------------------------
module tcee_queue
	import tcee_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: sv/tcee_back.sv
// ----------------------------------------------------------------------------
// tcee_back: result generator
// Turns each queued command into one or two result transfers, computing the
// screen cell offsets, and holds them in the output register.
// ----------------------------------------------------------------------------
module tcee_back
	import tcee_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        head_valid,
	input  cmd_t        head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_last,
	output op_t         out_op,
	output logic [15:0] out_cell_offset,
	output logic [7:0]  out_cell_char,
	output logic [7:0]  out_cell_attrib,
	output logic [15:0] out_cursor_offset,
	output logic        out_bell
);

	logic        out_valid_q, out_last_q, out_bell_q, second_q;
	op_t         out_op_q;
	logic [15:0] out_cell_off_q, out_cur_off_q;
	logic [7:0]  out_char_q, out_attr_q;
	logic [14:0] wr_prod, cur_prod;
	logic [15:0] wr_off, cur_off;
	logic        load;

	assign wr_prod  = 15'(head.wr_row) * 15'(cfg.screen_stride);
	assign cur_prod = 15'(head.cur_row) * 15'(cfg.screen_stride);
	assign wr_off   = cfg.window_offset + 16'(wr_prod) + 16'(head.wr_col);
	assign cur_off  = cfg.window_offset + 16'(cur_prod) + 16'(head.cur_col);

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && (second_q || !head.scroll2);

	always_ff @(posedge clk) begin
		if (load) begin
			out_cur_off_q <= cur_off;
			if (second_q) begin
				out_op_q       <= OP_SCROLL;
				out_cell_off_q <= '0;
				out_char_q     <= '0;
				out_attr_q     <= head.attr;
				out_bell_q     <= 1'b0;
				out_last_q     <= 1'b1;
			end else begin
				out_op_q       <= head.op;
				out_cell_off_q <= (head.op == OP_WRITE) ? wr_off : '0;
				out_char_q     <= head.ch;
				out_attr_q     <= head.attr;
				out_bell_q     <= head.bell;
				out_last_q     <= !head.scroll2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				second_q    <= !second_q && head.scroll2;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign out_last          = out_last_q;
	assign out_op            = out_op_q;
	assign out_cell_offset   = out_cell_off_q;
	assign out_cell_char     = out_char_q;
	assign out_cell_attrib   = out_attr_q;
	assign out_cursor_offset = out_cur_off_q;
	assign out_bell          = out_bell_q;

endmodule

FILE: sv/text_console_escape_engine_unit.sv
// ----------------------------------------------------------------------------
// text_console_escape_engine_unit: ANSI text console engine
// Cursor, attribute and escape handling for a text-mode console window.
// ----------------------------------------------------------------------------
// Each byte on the slave stream is interpreted like a console terminal would:
// printable bytes become cell writes at the cursor, the controls BEL, BS, LF,
// FF, CR and DEL act on the cursor (BEL rings the bell if enabled), and the sequences ESC[0m, ESC[01m,
// ESC[04m, ESC[30m..ESC[37m and ESC[A..D change the attribute or move the
// cursor on their final byte. Every byte produces one result transfer on the
// master stream, or two when a printable byte wraps past the bottom row (a
// cell write followed by a window scroll); tlast marks the final transfer of
// a byte, and every transfer of a byte carries the cursor offset after that
// byte. The front end takes one byte per clock while its command
// queue has room; the back end issues one result transfer per clock from its
// output register while the master stream accepts them. Configuration
// registers are written through the cfg port and should only be changed
// while no bytes are in flight.
module text_console_escape_engine_unit
	import tcee_pkg::*;
#(
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int MAX_COLS    = MAX_COLS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Character input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
	// Result output stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] cell_offset, [23:16] cell_char, [31:24] cell_attrib,
	// [47:32] cursor_offset, [48] bell, [55:49] zero
	output logic [55:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,   // [1:0] op
	output logic        m_axis_tlast
);

	cfg_t        cfg_q;
	cmd_t        front_cmd, head;
	logic        q_full, take, head_valid, pop;
	op_t         out_op;
	logic [15:0] out_cell_offset, out_cursor_offset;
	logic [7:0]  out_cell_char, out_cell_attrib;
	logic        out_bell;

	// Configuration registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_offset  <= 16'd0;
			cfg_q.window_height  <= 7'd25;
			cfg_q.window_width   <= 9'd80;
			cfg_q.screen_stride  <= 9'd80;
			cfg_q.auto_line_feed <= 1'b0;
			cfg_q.bell_enable    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_OFFSET:  cfg_q.window_offset  <= cfg_data;
				REG_WINDOW_HEIGHT:  cfg_q.window_height  <= cfg_data[6:0];
				REG_WINDOW_WIDTH:   cfg_q.window_width   <= cfg_data[8:0];
				REG_SCREEN_STRIDE:  cfg_q.screen_stride  <= cfg_data[8:0];
				REG_AUTO_LINE_FEED: cfg_q.auto_line_feed <= cfg_data[0];
				REG_BELL_ENABLE:    cfg_q.bell_enable    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// The front end updates the console state on every accepted byte and
	// pushes its command in the same cycle.
	assign s_axis_tready = !q_full;
	assign take          = s_axis_tvalid && s_axis_tready;

	tcee_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.take    (take),
		.char_in (s_axis_tdata),
		.cmd     (front_cmd)
	);

	tcee_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (take),
		.push_data  (front_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// The back end drains the queue, splitting a write-and-scroll command
	// into two transfers.
	tcee_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.head_valid        (head_valid),
		.head              (head),
		.pop               (pop),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.out_last          (m_axis_tlast),
		.out_op            (out_op),
		.out_cell_offset   (out_cell_offset),
		.out_cell_char     (out_cell_char),
		.out_cell_attrib   (out_cell_attrib),
		.out_cursor_offset (out_cursor_offset),
		.out_bell          (out_bell)
	);

	assign m_axis_tuser = out_op;
	assign m_axis_tdata = {7'd0, out_bell, out_cursor_offset, out_cell_attrib,
		out_cell_char, out_cell_offset};

`ifndef SYNTHESIS
	// Only a cell write is ever followed by a second transfer of the same byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == OP_WRITE)
		else $error("non-final transfer is not a cell write");

	// The transfer after a non-final write is the scroll of the same byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		m_axis_tvalid && m_axis_tlast && m_axis_tuser == OP_SCROLL)
		else $error("write with wrap not followed by a scroll");

	// The bell only rides on a single no-op transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[48] |->
		m_axis_tlast && m_axis_tuser == OP_NONE)
		else $error("bell on a transfer other than a lone no-op");

	// Only writes carry a cell offset.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != OP_WRITE |-> m_axis_tdata[15:0] == 16'd0)
		else $error("cell offset on a transfer that is not a write");
`endif

endmodule
